// File: sv/srsc_pkg.sv
// ----------------------------------------------------------------------------
// srsc_pkg: shared definitions for the speed ramp and steering controller
// Field widths, event and level codes, register indexes, reset values and the
// arctangent table of the vectoring CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srsc_pkg;

	// Parameter defaults.
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// Field widths.
	localparam int POS_W      = 32;  // Q16.16 position
	localparam int POS_FRAC   = 16;
	localparam int SPEED_W    = 24;  // Q8.16 speed
	localparam int LIMIT_W    = 17;  // Q1.16 steering limit
	localparam int STEER_W    = 18;  // signed Q2.16 steering
	localparam int ANGLE_W    = 20;  // CORDIC angle accumulator
	localparam int CORDIC_W   = 36;  // CORDIC vector width with growth margin
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Forward offsets at or below this magnitude give no steering (0.1 m).
	localparam logic [POS_W:0] NEAR_X_MAX = (POS_W + 1)'((1 << POS_FRAC) / 10);

	// Quarter turn in Q2.16 radians.
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16 = ANGLE_W'(102944);

	// Register reset values.
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = SPEED_W'(786432);
	localparam logic [LIMIT_W-1:0] STEER_LIMIT_RST = LIMIT_W'(28596);
	localparam logic [SPEED_W-1:0] BRAKE_STEP_RST  = SPEED_W'(8192);

	// Event kinds.
	typedef enum logic [1:0] {
		OP_WAYPOINT = 2'd0,
		OP_HAZARD   = 2'd1,
		OP_TICK     = 2'd2,
		OP_STOP_ACK = 2'd3
	} op_t;

	// Diagnostic levels.
	typedef enum logic [1:0] {
		LVL_OK    = 2'd0,
		LVL_WARN  = 2'd1,
		LVL_ERROR = 2'd2,
		LVL_STALE = 2'd3
	} level_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SPEED   = 2'd0,
		CFG_STEER_LIMIT = 2'd1,
		CFG_BRAKE_STEP  = 2'd2
	} cfg_reg_t;

	// Result kinds.
	localparam logic KIND_DRIVE = 1'b0;
	localparam logic KIND_STOP  = 1'b1;

	// atan(2^-i) in Q2.16 radians.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] val;
		unique case (idx)
			5'd0: val = 16'd51472;
			5'd1: val = 16'd30386;
			5'd2: val = 16'd16055;
			5'd3: val = 16'd8150;
			5'd4: val = 16'd4091;
			5'd5: val = 16'd2047;
			5'd6: val = 16'd1024;
			5'd7: val = 16'd512;
			5'd8: val = 16'd256;
			5'd9: val = 16'd128;
			5'd10: val = 16'd64;
			5'd11: val = 16'd32;
			5'd12: val = 16'd16;
			5'd13: val = 16'd8;
			5'd14: val = 16'd4;
			5'd15: val = 16'd2;
			5'd16: val = 16'd1;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// File: sv/srsc_cordic.sv
// ----------------------------------------------------------------------------
// srsc_cordic: iterative vectoring CORDIC for atan2(y, x)
// The add/subtract units and two arithmetic shifters are reused for STEPS
// iterations, after a quarter-turn pre-rotation for vectors with negative x.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srsc_cordic #(
	parameter int STEPS = srsc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [srsc_pkg::POS_W-1:0]    x,
	input  logic signed [srsc_pkg::POS_W-1:0]    y,
	output logic                                 busy,
	output logic signed [srsc_pkg::ANGLE_W-1:0]  angle
);
	import srsc_pkg::*;

	localparam int W = CORDIC_W;
	localparam logic [ATAN_IDX_W-1:0] LAST_ITER = ATAN_IDX_W'(STEPS - 1);

	logic                         busy_q;
	logic [ATAN_IDX_W-1:0]        iter_q;
	logic signed [W-1:0]          x_q, y_q;
	logic signed [ANGLE_W-1:0]    z_q;

	logic signed [W-1:0]          x_ext, y_ext, x_init, y_init;
	logic signed [ANGLE_W-1:0]    z_init;
	logic signed [W-1:0]          x_shift, y_shift;
	logic signed [ANGLE_W-1:0]    atan_val;
	logic                         y_pos;

	// Pre-rotation by a quarter turn brings the vector into the right half plane.
	always_comb begin
		x_ext = {{(W - POS_W){x[POS_W-1]}}, x};
		y_ext = {{(W - POS_W){y[POS_W-1]}}, y};
		if (x_ext < 0) begin
			if (y_ext >= 0) begin
				x_init = y_ext;
				y_init = -x_ext;
				z_init = HALF_PI_Q16;
			end else begin
				x_init = -y_ext;
				y_init = x_ext;
				z_init = -HALF_PI_Q16;
			end
		end else begin
			x_init = x_ext;
			y_init = y_ext;
			z_init = '0;
		end
	end

	// Shared shift and angle lookup for the current iteration.
	always_comb begin
		x_shift  = x_q >>> iter_q;
		y_shift  = y_q >>> iter_q;
		atan_val = $signed({{(ANGLE_W - ATAN_W){1'b0}}, atan_q16(iter_q)});
		y_pos    = !y_q[W-1] && (y_q != '0);
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (busy_q) begin
			if (iter_q == LAST_ITER) begin
				busy_q <= 1'b0;
			end
			iter_q <= iter_q + 1'b1;
		end
	end

	// Vector and angle datapath.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (busy_q) begin
			if (y_pos) begin
				x_q <= x_q + y_shift;
				y_q <= y_q - x_shift;
				z_q <= z_q + atan_val;
			end else begin
				x_q <= x_q - y_shift;
				y_q <= y_q + x_shift;
				z_q <= z_q - atan_val;
			end
		end
	end

	assign busy  = busy_q;
	assign angle = z_q;

endmodule

// File: sv/speed_ramp_steer_controller.sv
// ----------------------------------------------------------------------------
// speed_ramp_steer_controller: speed ramp and steering command generator
// Waypoint, hazard status and stop acknowledge requests are taken one per cycle
// while idle. A stop or braking command goes from accept to the emit state; a
// cruising tick passes the target, ramp, apply and steer states, the last waiting
// on the CORDIC with the ramp multiplier alongside. The input stalls until the
// result moves to the output register, so the next request can follow in the
// cycle after it. Reset initialises the control state, not the datapath registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speed_ramp_steer_controller #(
	parameter int CORDIC_STEPS  = srsc_pkg::CORDIC_STEPS_DEF,
	parameter int FRACTION_BITS = srsc_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [srsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srsc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Event requests
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           operation,
	input  logic signed [srsc_pkg::POS_W-1:0]    waypoint_x,
	input  logic signed [srsc_pkg::POS_W-1:0]    waypoint_y,
	input  logic [1:0]                           status_level,
	input  logic                                 last_status,
	input  logic                                 service_ready,
	// Result requests
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 result_kind,
	output logic [srsc_pkg::SPEED_W-1:0]         drive_speed,
	output logic signed [srsc_pkg::STEER_W-1:0]  drive_steering
);
	import srsc_pkg::*;

	localparam int COEF_W = FRACTION_BITS;
	localparam int PROD_W = SPEED_W + COEF_W;
	localparam logic [COEF_W-1:0] COEF_WARN = COEF_W'(((4 << FRACTION_BITS) + 5) / 10);
	localparam logic [COEF_W-1:0] COEF_RAMP = COEF_W'(((8 << FRACTION_BITS) + 50) / 100);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_TARGET = 6'b000010,
		S_RAMP   = 6'b000100,
		S_APPLY  = 6'b001000,
		S_STEER  = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t                      state_q;
	logic [SPEED_W-1:0]          max_speed_q, brake_step_q;
	logic [LIMIT_W-1:0]          steer_limit_q;
	logic [SPEED_W-1:0]          speed_q;
	logic signed [POS_W-1:0]     target_x_q, target_y_q;
	logic                        route_q, emerg_q;
	logic [1:0]                  hazard_q, pending_q;
	logic                        out_valid_q;

	logic [SPEED_W-1:0]          tgt_spd_q, delta_q;
	logic                        delta_neg_q, far_q;
	logic                        res_kind_q;
	logic [SPEED_W-1:0]          res_speed_q;
	logic signed [STEER_W-1:0]   res_steer_q;
	logic                        out_kind_q;
	logic [SPEED_W-1:0]          out_speed_q;
	logic signed [STEER_W-1:0]   out_steer_q;

	logic                        accept, out_free;
	op_t                         op;
	level_t                      level;
	logic [1:0]                  pend_next;
	logic                        stop_req, brake_tick, cruise_tick, steer_done;
	logic [SPEED_W-1:0]          brake_speed;
	logic [SPEED_W-1:0]          mul_a;
	logic [COEF_W-1:0]           mul_b;
	logic [PROD_W-1:0]           prod, prod_rnd;
	logic [SPEED_W-1:0]          prod_q16;
	logic signed [SPEED_W:0]     diff, diff_neg_val;
	logic [SPEED_W-1:0]          diff_mag;
	logic signed [SPEED_W+1:0]   ramp_sum;
	logic [SPEED_W-1:0]          ramp_speed;
	logic [POS_W:0]              abs_x;
	logic                        x_far;
	logic                        cordic_busy;
	logic signed [ANGLE_W-1:0]   angle, lim, steer_val;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign op        = op_t'(operation);
	assign level     = level_t'(status_level);

	// Alert folding: error beats warn beats ok; stale leaves the level alone.
	always_comb begin
		if (level == LVL_ERROR) begin
			pend_next = LVL_ERROR;
		end else if (level == LVL_WARN && pending_q != LVL_ERROR) begin
			pend_next = LVL_WARN;
		end else begin
			pend_next = pending_q;
		end
	end

	// Event decode.
	always_comb begin
		stop_req    = accept && op == OP_HAZARD && last_status && pend_next == LVL_ERROR
			&& !emerg_q && service_ready;
		brake_tick  = accept && op == OP_TICK && (emerg_q || !route_q);
		cruise_tick = accept && op == OP_TICK && !emerg_q && route_q;
		steer_done  = (state_q == S_STEER) && !cordic_busy;
		brake_speed = (speed_q > brake_step_q) ? speed_q - brake_step_q : '0;
	end

	// Shared multiplier: warn target first, then the ramp step.
	always_comb begin
		diff         = $signed({1'b0, tgt_spd_q}) - $signed({1'b0, speed_q});
		diff_neg_val = -diff;
		diff_mag     = diff[SPEED_W] ? diff_neg_val[SPEED_W-1:0] : diff[SPEED_W-1:0];
		mul_a        = (state_q == S_RAMP) ? diff_mag : max_speed_q;
		mul_b        = (state_q == S_RAMP) ? COEF_RAMP : COEF_WARN;
		prod         = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_rnd     = prod + ROUND_HALF;
		prod_q16     = prod_rnd[FRACTION_BITS +: SPEED_W];
	end

	// Apply the ramp step and clamp to the speed range.
	always_comb begin
		if (delta_neg_q) begin
			ramp_sum = $signed({2'b00, speed_q}) - $signed({2'b00, delta_q});
		end else begin
			ramp_sum = $signed({2'b00, speed_q}) + $signed({2'b00, delta_q});
		end
		if (ramp_sum[SPEED_W+1]) begin
			ramp_speed = '0;
		end else if (ramp_sum[SPEED_W]) begin
			ramp_speed = '1;
		end else begin
			ramp_speed = ramp_sum[SPEED_W-1:0];
		end
	end

	// Steering dead zone and clamp.
	always_comb begin
		abs_x = target_x_q[POS_W-1] ? -{1'b1, target_x_q} : {1'b0, target_x_q};
		x_far = abs_x > NEAR_X_MAX;
		lim   = $signed({{(ANGLE_W - LIMIT_W){1'b0}}, steer_limit_q});
		if (!far_q) begin
			steer_val = '0;
		end else if (angle > lim) begin
			steer_val = lim;
		end else if (angle < -lim) begin
			steer_val = -lim;
		end else begin
			steer_val = angle;
		end
	end

	srsc_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cruise_tick),
		.x     (target_x_q),
		.y     (target_y_q),
		.busy  (cordic_busy),
		.angle (angle)
	);

	// Sequencer, configuration and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_speed_q   <= MAX_SPEED_RST;
			steer_limit_q <= STEER_LIMIT_RST;
			brake_step_q  <= BRAKE_STEP_RST;
			speed_q       <= '0;
			target_x_q    <= '0;
			target_y_q    <= '0;
			route_q       <= 1'b0;
			emerg_q       <= 1'b0;
			hazard_q      <= LVL_OK;
			pending_q     <= LVL_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAX_SPEED:   max_speed_q   <= cfg_data;
					CFG_STEER_LIMIT: steer_limit_q <= cfg_data[LIMIT_W-1:0];
					CFG_BRAKE_STEP:  brake_step_q  <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_WAYPOINT: begin
								target_x_q <= waypoint_x;
								target_y_q <= waypoint_y;
								route_q    <= 1'b1;
							end
							OP_HAZARD: begin
								if (last_status) begin
									hazard_q  <= pend_next;
									pending_q <= LVL_OK;
									if (pend_next == LVL_ERROR && !emerg_q) begin
										emerg_q <= 1'b1;
									end
								end else begin
									pending_q <= pend_next;
								end
								if (stop_req) begin
									state_q <= S_EMIT;
								end
							end
							OP_STOP_ACK: begin
								emerg_q <= 1'b0;
							end
							OP_TICK: begin
								if (brake_tick) begin
									speed_q <= brake_speed;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_TARGET;
								end
							end
							default: ;
						endcase
					end
				end
				S_TARGET: state_q <= S_RAMP;
				S_RAMP:   state_q <= S_APPLY;
				S_APPLY: begin
					speed_q <= ramp_speed;
					state_q <= S_STEER;
				end
				S_STEER: begin
					if (steer_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Output register: load a finished result, drop a taken one.
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		if (cruise_tick) begin
			far_q <= x_far;
		end
		if (state_q == S_TARGET) begin
			tgt_spd_q <= (hazard_q == LVL_WARN) ? prod_q16 : max_speed_q;
		end
		if (state_q == S_RAMP) begin
			delta_q     <= prod_q16;
			delta_neg_q <= diff[SPEED_W];
		end
		if (stop_req) begin
			res_kind_q  <= KIND_STOP;
			res_speed_q <= '0;
			res_steer_q <= '0;
		end else if (brake_tick) begin
			res_kind_q  <= KIND_DRIVE;
			res_speed_q <= brake_speed;
			res_steer_q <= '0;
		end else if (steer_done) begin
			res_kind_q  <= KIND_DRIVE;
			res_speed_q <= speed_q;
			res_steer_q <= steer_val[STEER_W-1:0];
		end
		if (state_q == S_EMIT && out_free) begin
			out_kind_q  <= res_kind_q;
			out_speed_q <= res_speed_q;
			out_steer_q <= res_steer_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign drive_speed    = out_speed_q;
	assign drive_steering = out_steer_q;

`ifndef SYNTHESIS
	// A stop request carries no speed and no steering.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STOP |-> drive_speed == '0 && drive_steering == '0)
		else $error("stop request with nonzero drive fields");

	// Emergency is entered only by an accepted hazard status.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(emerg_q) |-> $past(accept && op == OP_HAZARD && last_status))
		else $error("emergency entered without a final hazard status");

	// Emergency is left only by an accepted stop acknowledge.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(emerg_q) |-> $past(accept && op == OP_STOP_ACK))
		else $error("emergency cleared without a stop acknowledge");

	// A new result appears only out of the emit state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside the emit state");
`endif

endmodule

// File: dv/srsc_command_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsc_command_checker: drive command and stop request checker
// Watches the event, configuration and result channels of the speed ramp and
// steering controller. It keeps its own copy of the controller state and
// registers and works out the expected result of each accepted request. Each
// accepted result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------

module srsc_command_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [srsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic signed [srsc_pkg::POS_W-1:0]   waypoint_x,
	input  logic signed [srsc_pkg::POS_W-1:0]   waypoint_y,
	input  logic [1:0]                          status_level,
	input  logic                                last_status,
	input  logic                                service_ready,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                result_kind,
	input  logic [srsc_pkg::SPEED_W-1:0]        drive_speed,
	input  logic signed [srsc_pkg::STEER_W-1:0] drive_steering,
	output int                                  fail_count,
	output int                                  outstanding
);
	import srsc_pkg::*;

	localparam int     FRAC         = FRACTION_BITS_DEF;
	localparam int     ITERATIONS   = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
	localparam longint ROUND_HALF   = longint'(1) << (FRAC - 1);
	localparam longint WARN_SCALE   = ((longint'(4) << FRAC) + 5) / 10;
	localparam longint RAMP_SCALE   = ((longint'(8) << FRAC) + 50) / 100;
	localparam longint SPEED_TOP    = (longint'(1) << SPEED_W) - 1;
	localparam longint DEAD_BAND_10 = longint'(1) << POS_FRAC;
	localparam longint QUARTER_TURN = 102944;

	typedef struct packed {
		logic                      kind;
		logic [SPEED_W-1:0]        speed;
		logic signed [STEER_W-1:0] steer;
	} command_t;

	// atan(2^-i) in Q2.16 radians; the steps past 16 add nothing.
	int angle_step [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	command_t expected_q [$];
	command_t due;
	int       fails = 0;

	// Registers and controller state.
	logic [SPEED_W-1:0]      max_speed_r   = MAX_SPEED_RST;
	logic [LIMIT_W-1:0]      steer_limit_r = STEER_LIMIT_RST;
	logic [SPEED_W-1:0]      brake_step_r  = BRAKE_STEP_RST;
	logic [SPEED_W-1:0]      speed_now     = '0;
	logic signed [POS_W-1:0] goal_x        = '0;
	logic signed [POS_W-1:0] goal_y        = '0;
	logic                    route_known   = 1'b0;
	logic                    in_emergency  = 1'b0;
	level_t                  hazard_now    = LVL_OK;
	level_t                  hazard_pending = LVL_OK;

	// Vectoring CORDIC toward (x, y), with a quarter-turn pre-rotation on the left half.
	function automatic longint heading_angle(input longint y, input longint x);
		longint z, t, xs, ys;
		int     i;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x;
				x = y;
				y = -t;
				z = QUARTER_TURN;
			end else begin
				t = x;
				x = -y;
				y = t;
				z = -QUARTER_TURN;
			end
		end
		for (i = 0; i < ITERATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + angle_step[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - angle_step[i];
			end
		end
		return z;
	endfunction

	// Applies one accepted event to the controller state and queues its result.
	task automatic advance_controller();
		longint   goal, diff, mag, delta, spd, steer, lim, ax;
		command_t cmd;
		cmd = '0;
		case (operation)
			OP_WAYPOINT: begin
				goal_x = waypoint_x;
				goal_y = waypoint_y;
				route_known = 1'b1;
			end
			OP_HAZARD: begin
				if (status_level == LVL_ERROR)
					hazard_pending = LVL_ERROR;
				else if (status_level == LVL_WARN && hazard_pending != LVL_ERROR)
					hazard_pending = LVL_WARN;
				if (last_status) begin
					hazard_now = hazard_pending;
					hazard_pending = LVL_OK;
					if (hazard_now == LVL_ERROR && !in_emergency) begin
						in_emergency = 1'b1;
						if (service_ready) begin
							cmd.kind = KIND_STOP;
							expected_q.push_back(cmd);
						end
					end
				end
			end
			OP_STOP_ACK: begin
				in_emergency = 1'b0;
			end
			OP_TICK: begin
				cmd.kind = KIND_DRIVE;
				if (in_emergency || !route_known) begin
					// Braking: speed falls by the brake step and stops at zero.
					speed_now = (speed_now > brake_step_r) ? speed_now - brake_step_r : '0;
				end else begin
					// Cruising: move a fixed share of the way toward the target.
					goal = longint'(max_speed_r);
					if (hazard_now == LVL_WARN)
						goal = (longint'(max_speed_r) * WARN_SCALE + ROUND_HALF) >>> FRAC;
					diff = goal - longint'(speed_now);
					mag = (diff < 0) ? -diff : diff;
					delta = (mag * RAMP_SCALE + ROUND_HALF) >>> FRAC;
					if (diff < 0)
						delta = -delta;
					spd = longint'(speed_now) + delta;
					if (spd < 0)
						spd = 0;
					if (spd > SPEED_TOP)
						spd = SPEED_TOP;
					speed_now = spd[SPEED_W-1:0];

					// Steering toward the waypoint, zero inside the dead band.
					steer = 0;
					ax = longint'(goal_x);
					if (ax < 0)
						ax = -ax;
					if (ax * 10 > DEAD_BAND_10)
						steer = heading_angle(longint'(goal_y), longint'(goal_x));
					lim = longint'(steer_limit_r);
					if (steer > lim)
						steer = lim;
					if (steer < -lim)
						steer = -lim;
					cmd.steer = steer[STEER_W-1:0];
				end
				cmd.speed = speed_now;
				expected_q.push_back(cmd);
			end
		endcase
	endtask

	task automatic report(input string field, input longint want, input longint got);
		fails++;
		$error("%s: expected %0d, actual %0d", field, want, got);
	endtask

	// Compare results first, then take register writes and new requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_r = MAX_SPEED_RST;
			steer_limit_r = STEER_LIMIT_RST;
			brake_step_r = BRAKE_STEP_RST;
			speed_now = '0;
			goal_x = '0;
			goal_y = '0;
			route_known = 1'b0;
			in_emergency = 1'b0;
			hazard_now = LVL_OK;
			hazard_pending = LVL_OK;
			expected_q.delete();
			outstanding <= 0;
			fail_count <= fails;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fails++;
					$error("unexpected result: kind %0d speed %0d steering %0d",
						result_kind, drive_speed, drive_steering);
				end else begin
					due = expected_q.pop_front();
					if (result_kind !== due.kind)
						report("result_kind", due.kind, result_kind);
					if (drive_speed !== due.speed)
						report("drive_speed", due.speed, drive_speed);
					if (drive_steering !== due.steer)
						report("drive_steering", due.steer, drive_steering);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_SPEED:   max_speed_r = cfg_data[SPEED_W-1:0];
					CFG_STEER_LIMIT: steer_limit_r = cfg_data[LIMIT_W-1:0];
					CFG_BRAKE_STEP:  brake_step_r = cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_controller();
			outstanding <= expected_q.size();
			fail_count <= fails;
		end
	end

endmodule

// File: dv/speed_ramp_steer_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_ramp_steer_controller_test: testbench of the speed ramp controller
// Sends a directed set of events with the reset register values, then random
// event streams under several register settings, with random gaps on the
// request side and random stalls on the result side. A separate checker
// predicts every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module speed_ramp_steer_controller_test;
	import srsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 180;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                operation = OP_WAYPOINT;
	logic signed [POS_W-1:0]   waypoint_x = '0;
	logic signed [POS_W-1:0]   waypoint_y = '0;
	logic [1:0]                status_level = LVL_OK;
	logic                      last_status = 1'b0;
	logic                      service_ready = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      result_kind;
	logic [SPEED_W-1:0]        drive_speed;
	logic signed [STEER_W-1:0] drive_steering;

	int fail_count;
	int outstanding;
	int idle_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	speed_ramp_steer_controller uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.waypoint_x     (waypoint_x),
		.waypoint_y     (waypoint_y),
		.status_level   (status_level),
		.last_status    (last_status),
		.service_ready  (service_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.drive_speed    (drive_speed),
		.drive_steering (drive_steering)
	);

	srsc_command_checker command_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.waypoint_x     (waypoint_x),
		.waypoint_y     (waypoint_y),
		.status_level   (status_level),
		.last_status    (last_status),
		.service_ready  (service_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.drive_speed    (drive_speed),
		.drive_steering (drive_steering),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	// Result side stalls in random bursts of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: too long without an accepted request, register write or taken result ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("speed_ramp_steer_controller test failed");
					$finish;
				end
			end
		end
	end

	// Sends one event request, sometimes after a random gap, and waits until it is taken.
	task automatic put_event(input op_t op, input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
		input level_t lvl, input logic last, input logic ready);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		waypoint_x <= x;
		waypoint_y <= y;
		status_level <= lvl;
		last_status <= last;
		service_ready <= ready;
		do @(posedge clk); while (in_stall);
	endtask

	// Event whose waypoint and status fields carry random noise.
	task automatic put_plain(input op_t op);
		put_event(op, $urandom(), $urandom(), level_t'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Writes every register index in one burst, the unused one included.
	task automatic load_registers(input logic [CFG_DATA_W-1:0] speed_cap,
		input logic [CFG_DATA_W-1:0] steer_cap, input logic [CFG_DATA_W-1:0] brake);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		int                    i;
		idx[0] = CFG_MAX_SPEED;
		idx[1] = CFG_STEER_LIMIT;
		idx[2] = CFG_BRAKE_STEP;
		idx[3] = CFG_SPARE;
		val[0] = speed_cap;
		val[1] = steer_cap;
		val[2] = brake;
		val[3] = CFG_DATA_W'($urandom());
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Lets every expected result arrive and the block fall idle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Waypoint offsets: mostly within 50 m, some near the dead band, some extreme.
	function automatic logic [POS_W-1:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 13108) - 6554;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 6553600) - 3276800;
		endcase
	endfunction

	function automatic level_t pick_level();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return LVL_OK;
		if (roll < 70)
			return LVL_WARN;
		if (roll < 85)
			return LVL_ERROR;
		return LVL_STALE;
	endfunction

	// Random stream of ticks, waypoints, whole alerts and acknowledges, with noise.
	task automatic run_random(input int count);
		int made, parts, k, pick;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				put_plain(OP_TICK);
				made++;
			end else if (pick < 55) begin
				put_event(OP_WAYPOINT, pick_offset(), pick_offset(), level_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				made++;
			end else if (pick < 75) begin
				parts = $urandom_range(1, 4);
				for (k = 0; k < parts; k++)
					put_event(OP_HAZARD, $urandom(), $urandom(), pick_level(), k == parts - 1,
						$urandom_range(0, 3) != 0);
				made += parts;
			end else if (pick < 85) begin
				put_plain(OP_STOP_ACK);
				made++;
			end else begin
				put_plain(op_t'($urandom_range(0, 3)));
				made++;
			end
		end
	endtask

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the registers at their reset values.
		idle_pct = 20;
		// No route yet: the tick brakes, already at zero.
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		// Forward offset at the edge of the dead band, then just past it.
		put_event(OP_WAYPOINT, 32'sd6553, 32'sd65536, LVL_OK, 1'b0, 1'b0);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_WAYPOINT, -32'sd6554, 32'sd65536, LVL_OK, 1'b0, 1'b0);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		// Extreme offsets in both half planes.
		put_event(OP_WAYPOINT, 32'h7FFF_FFFF, 32'h8000_0000, LVL_OK, 1'b0, 1'b0);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_WAYPOINT, 32'h8000_0000, 32'h7FFF_FFFF, LVL_OK, 1'b0, 1'b0);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_WAYPOINT, -32'sd65536, -32'sd1, LVL_OK, 1'b0, 1'b0);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		// A warning lowers the cruise target; a stale last status commits ok.
		put_event(OP_HAZARD, '0, '0, LVL_WARN, 1'b1, 1'b1);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_HAZARD, '0, '0, LVL_STALE, 1'b1, 1'b1);
		// Error then warning: the error wins and a stop request goes out.
		put_event(OP_HAZARD, '0, '0, LVL_ERROR, 1'b0, 1'b1);
		put_event(OP_HAZARD, '0, '0, LVL_WARN, 1'b1, 1'b1);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_STOP_ACK, '0, '0, LVL_OK, 1'b0, 1'b0);
		// Acknowledge with no emergency pending.
		put_event(OP_STOP_ACK, '0, '0, LVL_OK, 1'b0, 1'b0);
		// Emergency while the stop service is busy: no stop request.
		put_event(OP_HAZARD, '0, '0, LVL_ERROR, 1'b1, 1'b0);
		put_event(OP_TICK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_STOP_ACK, '0, '0, LVL_OK, 1'b0, 1'b0);
		put_event(OP_HAZARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, LVL_OK, 1'b1, 1'b1);
		put_event(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, LVL_STALE, 1'b1, 1'b1);
		settle();

		// Random phases, each under its own register setting.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					load_registers(24'hFF_FFFF, 24'd131071, 24'hFF_FFFF);
					idle_pct = 25;
				end
				1: begin
					load_registers('0, '0, '0);
					idle_pct = 0;
				end
				2: begin
					load_registers(CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)), 24'd102944,
						CFG_DATA_W'($urandom_range(1, 65536)));
					idle_pct = 40;
				end
				3: begin
					load_registers(MAX_SPEED_RST, 24'(STEER_LIMIT_RST), BRAKE_STEP_RST);
					idle_pct = 15;
				end
				4: begin
					load_registers(CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)),
						CFG_DATA_W'($urandom()),
						CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)));
					idle_pct = 30;
				end
				default: begin
					load_registers(CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)),
						CFG_DATA_W'($urandom_range(0, 102944)),
						CFG_DATA_W'($urandom_range(0, 262144)));
					idle_pct = 0;
				end
			endcase
			run_random(PHASE_ITEMS);
			settle();
		end

		if (fail_count == 0)
			$display("speed_ramp_steer_controller test passed");
		else
			$display("speed_ramp_steer_controller test failed");
		$finish;
	end

endmodule
